FILE: design/srse_pkg.sv
// Shared types and constants of the substring equality block.
package srse_pkg;

    localparam int MAX_LEN_DEF     = 1024;
    localparam int RANK_LEVELS_DEF = 12;
    localparam int FIELD_W         = 10;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         char_value;
        logic [FIELD_W-1:0] first_start;
        logic [FIELD_W-1:0] first_end;
        logic [FIELD_W-1:0] second_start;
        logic [FIELD_W-1:0] second_end;
    } t_req;

    typedef struct packed {
        logic result_kind;
        logic equal;
        logic invalid;
    } t_rsp;

endpackage

FILE: design/srse_chan_if.sv
// Valid/ready channel carrying one payload per request.
interface srse_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/srse_ram.sv
// Simple dual-port RAM with registered read data.
module srse_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/suffix_rank_substring_equality_core.sv
// Substring equality core: string load, prefix-doubling rank build, range compare.
//
// An append is written in the cycle that it is taken. A build runs one level
// after another, at most RANK_LEVELS-1 levels. Each level fills the sort memory
// by insertion: per position it reads two ranks, makes the entry and shifts
// larger entries up one place until it finds its slot (up to n(n-1)/2 shifts,
// n string length). It then walks the sorted entries, with a read and a write
// state each, to write the next level's ranks. Both phases are bound by the
// single read port of the rank and sort memories. A query holds off the input
// until done and makes four rank memory reads; a bad range ends it at the
// range check, a length mismatch at the length check. A result then waits in
// a one-entry output register; the next request is taken once it is moved there.
module suffix_rank_substring_equality_core #(
    parameter int MAX_LEN     = srse_pkg::MAX_LEN_DEF,
    parameter int RANK_LEVELS = srse_pkg::RANK_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srse_chan_if.sink   i_req,
    srse_chan_if.source o_rsp
);
    localparam int P_W    = $clog2(MAX_LEN);
    localparam int N_W    = $clog2(MAX_LEN + 1);
    localparam int R_W    = (P_W > 8) ? P_W : 8;
    localparam int PAIR_W = 2 * R_W + 1;
    localparam int E_W    = PAIR_W + P_W;
    localparam int LV_W   = $clog2(RANK_LEVELS);
    localparam int DEPTH  = RANK_LEVELS * MAX_LEN;
    localparam int A_W    = $clog2(DEPTH);
    localparam int Q_W    = (N_W > srse_pkg::FIELD_W + 1) ? N_W : srse_pkg::FIELD_W + 1;
    localparam int G_W    = $clog2(Q_W);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LCHK = 5'd1;
    localparam logic [4:0] S_ARD0 = 5'd2;
    localparam logic [4:0] S_ARD1 = 5'd3;
    localparam logic [4:0] S_AMK  = 5'd4;
    localparam logic [4:0] S_AINS = 5'd5;
    localparam logic [4:0] S_ACMP = 5'd6;
    localparam logic [4:0] S_BRD  = 5'd7;
    localparam logic [4:0] S_BWR  = 5'd8;
    localparam logic [4:0] S_QCHK = 5'd9;
    localparam logic [4:0] S_QLEN = 5'd10;
    localparam logic [4:0] S_QR0  = 5'd11;
    localparam logic [4:0] S_QR1  = 5'd12;
    localparam logic [4:0] S_QR2  = 5'd13;
    localparam logic [4:0] S_QR3  = 5'd14;
    localparam logic [4:0] S_QFIN = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    function automatic logic [A_W-1:0] rank_addr(input logic [LV_W-1:0] lv,
                                                 input logic [P_W-1:0]  pos);
        return A_W'(32'(lv) * MAX_LEN + 32'(pos));
    endfunction

    logic [4:0]        r_state, n_state;
    logic [N_W-1:0]    r_len, n_len;
    logic              r_built, n_built;
    logic [LV_W-1:0]   r_lv, n_lv;
    logic [N_W-1:0]    r_step, n_step;
    logic [N_W-1:0]    r_k, n_k;
    logic [N_W-1:0]    r_p, n_p;
    logic [N_W-1:0]    r_j, n_j;
    logic [E_W-1:0]    r_e, n_e;
    logic [R_W-1:0]    r_ra, n_ra;
    logic [P_W-1:0]    r_rank, n_rank;
    logic [PAIR_W-1:0] r_prev, n_prev;
    srse_pkg::t_req    r_req, n_req;
    logic [Q_W-1:0]    r_len_q, n_len_q;
    logic              r_same, n_same;
    logic [LV_W-1:0]   r_g, n_g;
    logic [Q_W-1:0]    r_off, n_off;
    logic [R_W-1:0]    r_da, n_da;
    logic              r_eq0, n_eq0;
    srse_pkg::t_rsp    r_res, n_res;
    srse_pkg::t_rsp    r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              rk_we;
    logic [A_W-1:0]    rk_waddr, rk_raddr;
    logic [R_W-1:0]    rk_wdata, rk_rdata;
    logic              so_we;
    logic [P_W-1:0]    so_waddr, so_raddr;
    logic [E_W-1:0]    so_wdata, so_rdata;

    logic              req_fire;
    logic [N_W:0]      p_plus_step;
    logic              has_second;
    logic [Q_W-1:0]    qa, qb, qc, qd, qn;
    logic [G_W-1:0]    g_msb;
    logic [Q_W-1:0]    off_c;

    srse_ram #(.W(R_W), .DEPTH(DEPTH)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rk_we),
        .i_waddr (rk_waddr),
        .i_wdata (rk_wdata),
        .i_raddr (rk_raddr),
        .o_rdata (rk_rdata)
    );

    srse_ram #(.W(E_W), .DEPTH(MAX_LEN)) u_sort_ram (
        .i_clk   (i_clk),
        .i_we    (so_we),
        .i_waddr (so_waddr),
        .i_wdata (so_wdata),
        .i_raddr (so_raddr),
        .o_rdata (so_rdata)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign req_fire      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    assign p_plus_step = (N_W+1)'(r_p) + (N_W+1)'(r_step);
    assign has_second  = p_plus_step < (N_W+1)'(r_len);

    assign qa = Q_W'(r_req.first_start);
    assign qb = Q_W'(r_req.first_end);
    assign qc = Q_W'(r_req.second_start);
    assign qd = Q_W'(r_req.second_end);
    assign qn = Q_W'(r_len);

    // msb of the common length picks the window level; clearing it gives the offset
    always_comb begin
        g_msb = '0;
        for (int q = 0; q < Q_W; q++) begin
            if (r_len_q[q]) begin
                g_msb = G_W'(q);
            end
        end
        off_c        = r_len_q;
        off_c[g_msb] = 1'b0;
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_built     = r_built;
        n_lv        = r_lv;
        n_step      = r_step;
        n_k         = r_k;
        n_p         = r_p;
        n_j         = r_j;
        n_e         = r_e;
        n_ra        = r_ra;
        n_rank      = r_rank;
        n_prev      = r_prev;
        n_req       = r_req;
        n_len_q     = r_len_q;
        n_same      = r_same;
        n_g         = r_g;
        n_off       = r_off;
        n_da        = r_da;
        n_eq0       = r_eq0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        rk_we       = 1'b0;
        rk_waddr    = rank_addr('0, r_len[P_W-1:0]);
        rk_wdata    = R_W'(i_req.payload.char_value);
        rk_raddr    = rank_addr(r_lv, r_p[P_W-1:0]);
        so_we       = 1'b0;
        so_waddr    = r_j[P_W-1:0];
        so_wdata    = r_e;
        so_raddr    = r_p[P_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_req = i_req.payload;
                    priority case (i_req.payload.command)
                        srse_pkg::CMD_APPEND: begin
                            // level 0 of the rank store doubles as the text
                            if (32'(r_len) < MAX_LEN) begin
                                rk_we   = 1'b1;
                                n_len   = r_len + N_W'(1);
                                n_built = 1'b0;
                            end
                        end
                        srse_pkg::CMD_BUILD: begin
                            if (r_len == '0) begin
                                n_res   = '{srse_pkg::KIND_BUILD, 1'b0, 1'b1};
                                n_state = S_DONE;
                            end else begin
                                n_lv    = '0;
                                n_step  = N_W'(1);
                                n_k     = r_len;
                                n_state = S_LCHK;
                            end
                        end
                        srse_pkg::CMD_QUERY: begin
                            n_state = S_QCHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LCHK: begin
                if (r_k == '0 || 32'(r_lv) + 1 >= RANK_LEVELS) begin
                    n_built = 1'b1;
                    n_res   = '{srse_pkg::KIND_BUILD, 1'b0, 1'b0};
                    n_state = S_DONE;
                end else begin
                    n_p     = '0;
                    n_state = S_ARD0;
                end
            end
            S_ARD0: begin
                rk_raddr = rank_addr(r_lv, r_p[P_W-1:0]);
                n_state  = S_ARD1;
            end
            S_ARD1: begin
                n_ra     = rk_rdata;
                rk_raddr = rank_addr(r_lv, p_plus_step[P_W-1:0]);
                n_state  = S_AMK;
            end
            S_AMK: begin
                // second key is rank+1, or 0 past the end
                n_e     = {r_ra,
                           has_second ? ((R_W+1)'(rk_rdata) + (R_W+1)'(1)) : (R_W+1)'(0),
                           r_p[P_W-1:0]};
                n_j     = r_p;
                n_state = S_AINS;
            end
            S_AINS: begin
                if (r_j == '0) begin
                    so_we    = 1'b1;
                    so_waddr = '0;
                    so_wdata = r_e;
                    n_p      = r_p + N_W'(1);
                    n_state  = (r_p + N_W'(1) == r_len) ? S_BRD : S_ARD0;
                    if (r_p + N_W'(1) == r_len) begin
                        n_p = '0;
                    end
                end else begin
                    so_raddr = P_W'(r_j - N_W'(1));
                    n_state  = S_ACMP;
                end
            end
            S_ACMP: begin
                so_we    = 1'b1;
                so_waddr = r_j[P_W-1:0];
                if (r_e[E_W-1:P_W] < so_rdata[E_W-1:P_W]) begin
                    so_wdata = so_rdata;
                    n_j      = r_j - N_W'(1);
                    n_state  = S_AINS;
                end else begin
                    so_wdata = r_e;
                    n_p      = r_p + N_W'(1);
                    n_state  = S_ARD0;
                    if (r_p + N_W'(1) == r_len) begin
                        n_p     = '0;
                        n_state = S_BRD;
                    end
                end
            end
            S_BRD: begin
                so_raddr = r_p[P_W-1:0];
                n_state  = S_BWR;
            end
            S_BWR: begin
                if (r_p == '0) begin
                    n_rank = '0;
                end else if (r_prev < so_rdata[E_W-1:P_W]) begin
                    n_rank = r_rank + P_W'(1);
                end
                rk_we    = 1'b1;
                rk_waddr = rank_addr(r_lv + LV_W'(1), so_rdata[P_W-1:0]);
                rk_wdata = R_W'(n_rank);
                n_prev   = so_rdata[E_W-1:P_W];
                n_p      = r_p + N_W'(1);
                n_state  = S_BRD;
                if (r_p + N_W'(1) == r_len) begin
                    n_lv    = r_lv + LV_W'(1);
                    n_step  = r_step << 1;
                    n_k     = r_k >> 1;
                    n_state = S_LCHK;
                end
            end
            S_QCHK: begin
                n_len_q = qb - qa + Q_W'(1);
                n_same  = (qb - qa) == (qd - qc);
                if (!r_built || qa > qb || qc > qd || qb >= qn || qd >= qn) begin
                    n_res   = '{srse_pkg::KIND_QUERY, 1'b0, 1'b1};
                    n_state = S_DONE;
                end else begin
                    n_state = S_QLEN;
                end
            end
            S_QLEN: begin
                n_g   = LV_W'(g_msb);
                n_off = off_c;
                if (!r_same) begin
                    n_res   = '{srse_pkg::KIND_QUERY, 1'b0, 1'b0};
                    n_state = S_DONE;
                end else if (32'(g_msb) >= RANK_LEVELS) begin
                    n_res   = '{srse_pkg::KIND_QUERY, 1'b0, 1'b1};
                    n_state = S_DONE;
                end else begin
                    n_state = S_QR0;
                end
            end
            S_QR0: begin
                rk_raddr = rank_addr(r_g, P_W'(qa));
                n_state  = S_QR1;
            end
            S_QR1: begin
                rk_raddr = rank_addr(r_g, P_W'(qc));
                n_da     = rk_rdata;
                n_state  = S_QR2;
            end
            S_QR2: begin
                rk_raddr = rank_addr(r_g, P_W'(qa + r_off));
                n_eq0    = (r_da == rk_rdata);
                n_state  = S_QR3;
            end
            S_QR3: begin
                rk_raddr = rank_addr(r_g, P_W'(qc + r_off));
                n_da     = rk_rdata;
                n_state  = S_QFIN;
            end
            S_QFIN: begin
                n_res   = '{srse_pkg::KIND_QUERY, r_eq0 && (r_da == rk_rdata), 1'b0};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
        r_lv    <= n_lv;
        r_step  <= n_step;
        r_k     <= n_k;
        r_p     <= n_p;
        r_j     <= n_j;
        r_e     <= n_e;
        r_ra    <= n_ra;
        r_rank  <= n_rank;
        r_prev  <= n_prev;
        r_req   <= n_req;
        r_len_q <= n_len_q;
        r_same  <= n_same;
        r_g     <= n_g;
        r_off   <= n_off;
        r_da    <= n_da;
        r_eq0   <= n_eq0;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    a_equal_only_valid_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.payload.equal |->
            o_rsp.payload.result_kind == srse_pkg::KIND_QUERY && !o_rsp.payload.invalid)
        else $error("equal flagged on a response that is not a valid query answer");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= MAX_LEN)
        else $error("string length beyond capacity");

    a_built_from_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_built) |-> $past(r_state) == S_LCHK)
        else $error("tables marked built outside the end of a build");

    a_insert_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AINS || r_state == S_ACMP) |-> r_j <= r_p && r_p < r_len)
        else $error("insertion index out of range");

endmodule
